// ===== design/assert_macros.svh =====
// Assertion macros used by longest_path_cycle_detect_core.
// No dependencies. Defining NO_ASSERTIONS turns every check into nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// A condition that must hold at every clock edge outside of reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant violated");
// A condition that must hold in the cycle after a trigger.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sequence violated");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/lpcd_pkg.sv =====
// Package for the longest path / positive cycle detection core.
// Sizes, edge and node table entry types and sequencer state type. No dependencies.
`timescale 1ns / 1ps
package lpcd_pkg;
   localparam int MAX_NODES = 1024;
   localparam int MAX_EDGES = 2048;
   localparam int NODE_W    = $clog2(MAX_NODES);   // node index
   localparam int NCFG_W    = NODE_W + 1;          // node count, holds MAX_NODES
   localparam int EDGE_AW   = $clog2(MAX_EDGES);   // edge table address
   localparam int CNT_W     = EDGE_AW + 1;         // edge count, holds MAX_EDGES
   localparam int ROUND_W   = NCFG_W + 1;          // holds 2*MAX_NODES-2
   localparam int SCORE_W   = 32;
   localparam int DIST_W    = 64;
   localparam int REQ_DATA_W = ((2 * NODE_W + SCORE_W + 7) / 8) * 8;
   localparam int RSP_USER_W = 3;

   typedef struct packed {
      logic [NODE_W-1:0]         src;
      logic [NODE_W-1:0]         dst;
      logic signed [SCORE_W-1:0] score;
   } edge_entry_type;

   typedef struct packed {
      logic                     valid;
      logic                     tainted;
      logic signed [DIST_W-1:0] best;
   } node_entry_type;

   typedef enum logic [7:0] {
      S_LOAD  = 8'b0000_0001,
      S_CLEAR = 8'b0000_0010,
      S_FETCH = 8'b0000_0100,
      S_NODE  = 8'b0000_1000,
      S_ADD   = 8'b0001_0000,
      S_UPD   = 8'b0010_0000,
      S_TREAD = 8'b0100_0000,
      S_TOUT  = 8'b1000_0000
   } state_type;
endpackage

// ===== design/longest_path_cycle_detect_core.sv =====
// Longest path scorer with positive cycle detection, Bellman-Ford style.
// Depends on lpcd_pkg and assert_macros.svh.
//
//   Channel | Dir | Beat content
//   req_    | in  | one edge; tlast marks the final edge of the graph
//   rsp_    | out | one result per graph: score in tdata, flags in tuser
//   csr_    | in  | node count write (11 bits)
//
// Edges load at one per cycle while req_tready is high; none are taken during a
// compute. The final edge starts a compute over n nodes in use and E stored
// edges: a clearing pass over the node table, then 2n-1 rounds of relaxation
// over every stored edge on the single shared add/compare datapath, one edge at a time.
// The result waits in an output register, so loading the next graph may
// start while it is stalled; the next result waits for that register to drain.
// Reset is synchronous and clears the control.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module longest_path_cycle_detect_core
   import lpcd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [9:0] src_node, [19:10] dst_node, [51:20] edge_score, [55:52] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,     // last_edge
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [63:0] best_score
   output logic [DIST_W-1:0]     rsp_tdata,
   // [0] unbounded, [1] reached, [2] edge_overflow
   output logic [RSP_USER_W-1:0] rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [NCFG_W-1:0]     csr_data
);

   state_type state_ff, state_in;
   logic [NCFG_W-1:0]  node_count_ff;
   logic [NCFG_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]   edge_cnt_ff, edge_cnt_in;
   logic               overflow_ff, overflow_in;
   logic [NCFG_W-1:0]  clr_ff, clr_in;
   logic [CNT_W-1:0]   eidx_ff, eidx_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic signed [DIST_W-1:0] cand_ff, cand_in;
   logic               skip_ff, skip_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]     rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   edge_entry_type edge_mem [MAX_EDGES];
   node_entry_type node_mem [MAX_NODES];
   edge_entry_type edge_q;
   node_entry_type rd_a_q, rd_b_q;
   logic [NODE_W-1:0] rd_a_addr;
   logic              nwr_en;
   logic [NODE_W-1:0] nwr_addr;
   node_entry_type    nwr_data;

   logic              req_acc;
   edge_entry_type    req_edge;
   logic [NCFG_W-1:0] n_eff;
   logic [ROUND_W-1:0] last_round;
   logic              mark;
   logic              improve;
   logic signed [DIST_W:0] sum_wide;

   assign req_tready = (state_ff == S_LOAD);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign req_edge.src   = req_tdata[NODE_W-1:0];
   assign req_edge.dst   = req_tdata[2*NODE_W-1:NODE_W];
   assign req_edge.score = req_tdata[2*NODE_W+SCORE_W-1:2*NODE_W];

   // Out-of-range node counts are pinned to the supported span.
   always_comb begin
      if (node_count_ff < NCFG_W'(2)) begin
         n_eff = NCFG_W'(2);
      end else if (node_count_ff > NCFG_W'(MAX_NODES)) begin
         n_eff = NCFG_W'(MAX_NODES);
      end else begin
         n_eff = node_count_ff;
      end
   end

   assign last_round = {n_ff, 1'b0} - ROUND_W'(2);
   assign mark       = (round_ff >= ({1'b0, n_ff} - ROUND_W'(1)));
   assign sum_wide   = {rd_a_q.best[DIST_W-1], rd_a_q.best}
                     + {{(DIST_W+1-SCORE_W){edge_q.score[SCORE_W-1]}}, edge_q.score};
   assign improve    = !rd_b_q.valid || (cand_ff > rd_b_q.best);
   // The target entry stays on port A while the result waits to be issued.
   assign rd_a_addr  = ((state_ff == S_TREAD) || (state_ff == S_TOUT))
                     ? NODE_W'(n_ff - NCFG_W'(1)) : edge_q.src;

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      edge_cnt_in  = edge_cnt_ff;
      overflow_in  = overflow_ff;
      clr_in       = clr_ff;
      eidx_in      = eidx_ff;
      round_in     = round_ff;
      cand_in      = cand_ff;
      skip_in      = skip_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      nwr_en       = 1'b0;
      nwr_addr     = edge_q.dst;
      nwr_data     = rd_b_q;
      case (state_ff)
         S_LOAD: begin
            if (req_acc) begin
               if (edge_cnt_ff < CNT_W'(MAX_EDGES)) begin
                  edge_cnt_in = edge_cnt_ff + CNT_W'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_tlast) begin
                  n_in     = n_eff;
                  clr_in   = '0;
                  round_in = '0;
                  state_in = S_CLEAR;
               end
            end
         end
         S_CLEAR: begin
            // Node 0 comes out of the clearing pass reached, at distance 0.
            nwr_en           = 1'b1;
            nwr_addr         = clr_ff[NODE_W-1:0];
            nwr_data.valid   = (clr_ff == '0);
            nwr_data.tainted = 1'b0;
            nwr_data.best    = '0;
            clr_in           = clr_ff + NCFG_W'(1);
            if (clr_ff == n_ff - NCFG_W'(1)) begin
               eidx_in  = '0;
               round_in = '0;
               state_in = (edge_cnt_ff == '0) ? S_TREAD : S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_NODE;
         end
         S_NODE: begin
            skip_in  = ({1'b0, edge_q.src} >= n_ff) || ({1'b0, edge_q.dst} >= n_ff);
            state_in = S_ADD;
         end
         S_ADD: begin
            if (sum_wide[DIST_W] != sum_wide[DIST_W-1]) begin
               cand_in = sum_wide[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}}
                                          : {1'b0, {(DIST_W-1){1'b1}}};
            end else begin
               cand_in = sum_wide[DIST_W-1:0];
            end
            skip_in  = skip_ff || !rd_a_q.valid;
            state_in = S_UPD;
         end
         S_UPD: begin
            if (!skip_ff) begin
               nwr_en           = 1'b1;
               nwr_data.valid   = 1'b1;
               nwr_data.best    = improve ? cand_ff : rd_b_q.best;
               nwr_data.tainted = rd_b_q.tainted
                                || (mark && (improve || rd_a_q.tainted));
            end
            state_in = S_FETCH;
            if (eidx_ff + CNT_W'(1) == edge_cnt_ff) begin
               eidx_in = '0;
               if (round_ff == last_round) begin
                  state_in = S_TREAD;
               end else begin
                  round_in = round_ff + ROUND_W'(1);
               end
            end else begin
               eidx_in = eidx_ff + CNT_W'(1);
            end
         end
         S_TREAD: begin
            state_in = S_TOUT;
         end
         S_TOUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (!rd_a_q.valid || rd_a_q.tainted) begin
                  rsp_data_in = '0;
               end else begin
                  rsp_data_in = rd_a_q.best;
               end
               rsp_user_in = {overflow_ff, rd_a_q.valid, rd_a_q.valid && rd_a_q.tainted};
               edge_cnt_in = '0;
               overflow_in = 1'b0;
               state_in    = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // Edge table: written while loading, read one edge per relaxation step.
   always_ff @(posedge clock) begin
      if (req_acc && (edge_cnt_ff < CNT_W'(MAX_EDGES))) begin
         edge_mem[edge_cnt_ff[EDGE_AW-1:0]] <= req_edge;
      end
      edge_q <= edge_mem[eidx_ff[EDGE_AW-1:0]];
   end

   // Node table: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (nwr_en) begin
         node_mem[nwr_addr] <= nwr_data;
      end
      rd_a_q <= node_mem[rd_a_addr];
      rd_b_q <= node_mem[edge_q.dst];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         node_count_ff <= NCFG_W'(2);
         n_ff          <= NCFG_W'(2);
         edge_cnt_ff   <= '0;
         overflow_ff   <= 1'b0;
         clr_ff        <= '0;
         eidx_ff       <= '0;
         round_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (csr_valid && csr_ready) begin
            node_count_ff <= csr_data;
         end
         n_ff          <= n_in;
         edge_cnt_ff   <= edge_cnt_in;
         overflow_ff   <= overflow_in;
         clr_ff        <= clr_in;
         eidx_ff       <= eidx_in;
         round_ff      <= round_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff     <= cand_in;
      skip_ff     <= skip_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   `ASSERT_NEXT(a_last_starts_clear, clock, reset, req_acc && req_tlast, state_ff == S_CLEAR)
   `ASSERT_ALWAYS(a_edge_cnt_bound, clock, reset, edge_cnt_ff <= CNT_W'(MAX_EDGES))
   `ASSERT_ALWAYS(a_round_bound, clock, reset, (state_ff == S_LOAD) || (round_ff <= last_round))
   `ASSERT_ALWAYS(a_rsp_from_tout, clock, reset, !$rose(rsp_valid_ff) || $past(state_ff == S_TOUT))
   `ASSERT_ALWAYS(a_idx_in_table, clock, reset, (state_ff != S_UPD) || (eidx_ff < edge_cnt_ff))

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for longest_path_cycle_detect_core: random edge streams in,
// scored graph results out, each compared with a scorer kept inside the bench.
// Depends on lpcd_pkg and the core itself.
`timescale 1ns / 1ps
module tb_top;
   import lpcd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 3_000_000;
   localparam int UNBOUNDED_BIT = 0;
   localparam int REACHED_BIT   = 1;
   localparam int OVERFLOW_BIT  = 2;

   typedef struct packed {
      logic [NODE_W-1:0]         src;
      logic [NODE_W-1:0]         dst;
      logic signed [SCORE_W-1:0] gain;
      logic                      last;
   } edge_beat_type;

   typedef struct packed {
      logic signed [DIST_W-1:0] best;
      logic                     unbounded;
      logic                     reached;
      logic                     overflow;
   } graph_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [DIST_W-1:0]     rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [NCFG_W-1:0]     csr_data = '0;

   longest_path_cycle_detect_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Scorer state: the bench's own copy of the edge table and node table.
   logic [NODE_W-1:0]         edge_from [MAX_EDGES];
   logic [NODE_W-1:0]         edge_to   [MAX_EDGES];
   logic signed [SCORE_W-1:0] edge_gain [MAX_EDGES];
   logic signed [DIST_W-1:0]  path_score  [MAX_NODES];
   bit                        node_known  [MAX_NODES];
   bit                        node_pumped [MAX_NODES];
   int unsigned               stored_edges = 0;
   bit                        edges_dropped = 1'b0;
   logic [NCFG_W-1:0]         node_count_reg = NCFG_W'(2);

   edge_beat_type    pending_edges[$];
   graph_result_type expected_scores[$];
   edge_beat_type    beat_on_bus;

   int unsigned cycle_count = 0;
   int unsigned send_gap = 0, ready_stall = 0;
   int unsigned req_burst = 0, rsp_burst = 0;
   int          fail_count = 0;
   int unsigned edges_queued = 0, edges_sent = 0, settings_used = 0;
   int unsigned results_seen = 0, unbounded_results = 0;
   int unsigned unreached_results = 0, overflow_results = 0;

   function automatic logic signed [DIST_W-1:0] add_clamped(logic signed [DIST_W-1:0] d,
                                                            logic signed [SCORE_W-1:0] w);
      logic signed [DIST_W:0] sum;
      sum = d + w;
      if (sum[DIST_W] != sum[DIST_W-1])
         return sum[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
      return sum[DIST_W-1:0];
   endfunction

   // One sweep over the stored edges in arrival order. In the second phase any
   // node that still improves, or sits downstream of such a node, is marked.
   function automatic void relax_pass(int unsigned n, bit mark);
      int unsigned s, t;
      logic signed [DIST_W-1:0] cand;
      for (int e = 0; e < int'(stored_edges); e++) begin
         s = edge_from[e];
         t = edge_to[e];
         if (s < n && t < n && node_known[s]) begin
            cand = add_clamped(path_score[s], edge_gain[e]);
            if (!node_known[t] || cand > path_score[t]) begin
               path_score[t] = cand;
               node_known[t] = 1'b1;
               if (mark) node_pumped[t] = 1'b1;
            end
            if (mark && node_pumped[s]) node_pumped[t] = 1'b1;
         end
      end
   endfunction

   function automatic void absorb_edge(edge_beat_type b);
      int unsigned n;
      graph_result_type res;
      if (stored_edges < MAX_EDGES) begin
         edge_from[stored_edges] = b.src;
         edge_to[stored_edges]   = b.dst;
         edge_gain[stored_edges] = b.gain;
         stored_edges++;
      end else begin
         edges_dropped = 1'b1;
      end
      if (!b.last) return;
      n = node_count_reg;
      if (n < 2) n = 2;
      if (n > MAX_NODES) n = MAX_NODES;
      for (int i = 0; i < int'(n); i++) begin
         path_score[i]  = '0;
         node_known[i]  = 1'b0;
         node_pumped[i] = 1'b0;
      end
      node_known[0] = 1'b1;
      for (int r = 0; r + 1 < int'(n); r++) relax_pass(n, 1'b0);
      for (int r = 0; r < int'(n); r++) relax_pass(n, 1'b1);
      res = '0;
      if (node_known[n-1]) begin
         res.reached = 1'b1;
         if (node_pumped[n-1]) res.unbounded = 1'b1;
         else res.best = path_score[n-1];
      end
      res.overflow = edges_dropped;
      expected_scores.insert(expected_scores.size(), res);
      stored_edges  = 0;
      edges_dropped = 1'b0;
   endfunction

   // Mostly back-to-back, some short gaps, a few long ones, and now and then
   // a stretch of several dozen beats with no gap at all.
   function automatic int unsigned idle_len(inout int unsigned burst);
      int unsigned r;
      if (burst > 0) begin
         burst--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) burst = $urandom_range(20, 80);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
         fail_count++;
      end
   endfunction

   function automatic void add_edge(logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst,
                                    logic signed [SCORE_W-1:0] gain, logic last);
      edge_beat_type b;
      b.src  = src;
      b.dst  = dst;
      b.gain = gain;
      b.last = last;
      pending_edges.insert(pending_edges.size(), b);
      edges_queued++;
   endfunction

   function automatic logic [NODE_W-1:0] pick_node(int unsigned n);
      if ($urandom_range(0, 15) == 0) return NODE_W'($urandom_range(0, MAX_NODES - 1));
      return NODE_W'($urandom_range(0, n - 1));
   endfunction

   function automatic logic signed [SCORE_W-1:0] pick_gain();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return 32'($urandom_range(0, 40)) - 32'd20;
      if (r < 65) return 32'($urandom_range(0, 120)) - 32'd100;
      if (r < 80) return $urandom();
      if (r < 92) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      return '0;
   endfunction

   // One random graph over n nodes, ending in a beat with tlast set.
   function automatic void enqueue_graph(int unsigned n, int unsigned count);
      edge_beat_type graph[$];
      edge_beat_type b;
      logic [NODE_W-1:0] tmp;
      int unsigned flavor, mid;
      flavor = $urandom_range(0, 9);
      b.last = 1'b0;
      for (int i = 0; i < int'(count); i++) begin
         b.src  = pick_node(n);
         b.dst  = pick_node(n);
         b.gain = pick_gain();
         // Forward-only graphs have no cycles, so their scores stay bounded.
         if (flavor < 4) begin
            if (b.src > b.dst) begin
               tmp   = b.src;
               b.src = b.dst;
               b.dst = tmp;
            end else if (b.src == b.dst) begin
               b.gain = -32'sd1;
            end
         end
         graph.insert(graph.size(), b);
      end
      if (flavor >= 3) begin
         // Give node 0 a route to the target, spliced in at random places.
         if (n <= 12) begin
            for (int i = 0; i + 1 < int'(n); i++) begin
               b.src  = NODE_W'(i);
               b.dst  = NODE_W'(i + 1);
               b.gain = pick_gain();
               graph.insert($urandom_range(0, graph.size()), b);
            end
         end else begin
            b.src  = '0;
            b.dst  = NODE_W'(n - 1);
            b.gain = pick_gain();
            graph.insert($urandom_range(0, graph.size()), b);
            if (n <= 64) begin
               mid    = $urandom_range(1, n - 2);
               b.dst  = NODE_W'(mid);
               b.gain = pick_gain();
               graph.insert($urandom_range(0, graph.size()), b);
               b.src  = NODE_W'(mid);
               b.dst  = NODE_W'(n - 1);
               b.gain = pick_gain();
               graph.insert($urandom_range(0, graph.size()), b);
            end
         end
      end
      graph[graph.size() - 1].last = 1'b1;
      foreach (graph[i]) add_edge(graph[i].src, graph[i].dst, graph[i].gain, graph[i].last);
   endfunction

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_edges.size() != 0 || req_tvalid || expected_scores.size() != 0);
   endtask

   task automatic write_node_count(logic [NCFG_W-1:0] v);
      wait_idle();
      // Every graph ends in a result, so the core is idle here; this is margin.
      repeat (16) @(posedge clock);
      csr_data  <= v;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      node_count_reg = v;
      settings_used++;
      @(negedge clock);
   endtask

   // Edge driver: pops the pending queue and holds each beat until accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            absorb_edge(beat_on_bus);
            edges_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_edges.size() != 0) begin
               beat_on_bus = pending_edges.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= REQ_DATA_W'({beat_on_bus.gain, beat_on_bus.dst, beat_on_bus.src});
               req_tlast  <= beat_on_bus.last;
               send_gap = idle_len(req_burst);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor with random back-pressure.
   always @(posedge clock) begin : rsp_monitor
      graph_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (!rsp_tuser[REACHED_BIT]) unreached_results++;
            if (rsp_tuser[UNBOUNDED_BIT]) unbounded_results++;
            if (rsp_tuser[OVERFLOW_BIT]) overflow_results++;
            if (expected_scores.size() == 0) begin
               $error("result beat arrived with no graph outstanding");
               fail_count++;
            end else begin
               want = expected_scores.pop_front();
               check_field("best_score", want.best, rsp_tdata);
               check_field("unbounded", 64'(want.unbounded), 64'(rsp_tuser[UNBOUNDED_BIT]));
               check_field("reached", 64'(want.reached), 64'(rsp_tuser[REACHED_BIT]));
               check_field("edge_overflow", 64'(want.overflow), 64'(rsp_tuser[OVERFLOW_BIT]));
            end
         end
         if (ready_stall > 0) begin
            ready_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            ready_stall = idle_len(rsp_burst);
         end
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAILURE");
      $finish;
   end

   initial begin
      logic [NCFG_W-1:0] fixed_settings[5];
      logic [NCFG_W-1:0] setting;
      int unsigned n, base, r;
      int p;
      fixed_settings = '{NCFG_W'(0), NCFG_W'(2047), NCFG_W'(1024), NCFG_W'(3), NCFG_W'(1023)};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed graphs at the reset node count of two.
      add_edge(10'd0, 10'd1, 32'sd5, 1'b1);
      add_edge(10'd0, 10'd1, 32'h7FFF_FFFF, 1'b1);
      add_edge(10'd0, 10'd1, 32'h8000_0000, 1'b1);
      add_edge(10'd0, 10'd1, -32'sd3, 1'b0);         // parallel edges, larger wins
      add_edge(10'd0, 10'd1, 32'sd9, 1'b1);
      add_edge(10'd1, 10'd0, 32'sd7, 1'b1);          // target not reachable
      add_edge(10'd0, 10'd1023, -32'sd1, 1'b0);      // edges outside the graph are skipped
      add_edge(10'd1023, 10'd1, 32'sd4, 1'b1);
      add_edge(10'd0, 10'd1, 32'sd4, 1'b0);          // losing cycle stays bounded
      add_edge(10'd1, 10'd0, -32'sd5, 1'b1);
      add_edge(10'd0, 10'd1, 32'sd0, 1'b0);          // zero-gain cycle stays bounded
      add_edge(10'd1, 10'd0, 32'sd0, 1'b1);
      add_edge(10'd0, 10'd1, 32'sd2, 1'b0);          // winning cycle reaches the target
      add_edge(10'd1, 10'd0, 32'sd1, 1'b1);
      add_edge(10'd0, 10'd0, 32'sd1, 1'b0);          // winning self-loop at the source
      add_edge(10'd0, 10'd1, -32'sd7, 1'b1);
      add_edge(10'd1, 10'd1, 32'sd1, 1'b0);          // winning self-loop at the target
      add_edge(10'd0, 10'd1, 32'sd3, 1'b1);
      add_edge(10'd1023, 10'd1023, -32'sd1, 1'b1);

      // Fill the edge table and overfill it by one so the final beat is
      // dropped. Only losing gains, so the result stays bounded.
      write_node_count(NCFG_W'(1));
      for (int i = 0; i < MAX_EDGES + 1; i++)
         add_edge(NODE_W'($urandom_range(0, 3)), NODE_W'($urandom_range(0, 3)),
                  32'($urandom_range(0, 10)) - 32'd12, i == MAX_EDGES);

      base = edges_queued;
      p = 0;
      while (p < 5 || edges_queued - base < 800) begin
         if (p < 5) begin
            setting = fixed_settings[p];
         end else begin
            r = $urandom_range(0, 9);
            if (r < 7) setting = NCFG_W'($urandom_range(2, 12));
            else if (r < 9) setting = NCFG_W'($urandom_range(13, 64));
            else setting = NCFG_W'($urandom_range(0, 2047));
         end
         write_node_count(setting);
         n = setting;
         if (n < 2) n = 2;
         if (n > MAX_NODES) n = MAX_NODES;
         // Large node counts mean many relaxation sweeps, so keep those graphs tiny.
         if (n > 64) enqueue_graph(n, $urandom_range(1, 2));
         else repeat ($urandom_range(3, 8))
            enqueue_graph(n, (n <= 12) ? $urandom_range(1, 10) : $urandom_range(1, 6));
         p++;
      end

      wait_idle();
      repeat (64) @(posedge clock);
      $display("Scored %0d graphs from %0d edge beats under %0d node-count writes.",
               results_seen, edges_sent, settings_used);
      $display("Of those, %0d were unbounded, %0d unreached and %0d had dropped edges.",
               unbounded_results, unreached_results, overflow_results);
      if (fail_count == 0 && expected_scores.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
